[rtl/ecfr_pkg.sv]
// Shared types and constants for the escaped command frame receiver.
package ecfr_pkg;

    localparam int unsigned BYTE_W = 8;

    // Positions at or above this limit wrap back to zero before use.
    localparam logic [BYTE_W-1:0] WRAP_LIMIT = 8'd254;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COMMAND = 2'd2;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST     = 8'd92;
    localparam logic [BYTE_W-1:0] END_CODE_RST        = 8'd69;
    localparam logic [BYTE_W-1:0] INITIAL_COMMAND_RST = 8'd79;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Depth of the operation queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Operations handed from the classifier to the executor.
    typedef enum logic [1:0] {
        OP_DATA,
        OP_END,
        OP_HEADER
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } op_entry_t;

endpackage

[rtl/ecfr_if.sv]
// Handshake interfaces for the received bytes, the results and the configuration writes.
interface ecfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ecfr_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] position;
    logic [7:0] command_code;

    modport source (output valid, output kind, output payload_byte, output position,
                    output command_code, input ready);
    modport sink (input valid, input kind, input payload_byte, input position,
                  input command_code, output ready);
endinterface

interface ecfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ecfr_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ecfr_front.sv]
// Front part: accepts raw bytes, tracks the escape flag and classifies each byte.
module ecfr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ecfr_rx_if.sink               rx,
    input  logic [7:0]            escape_code,
    input  logic [7:0]            end_code,
    input  logic                  q_ready,
    output logic                  q_push,
    output ecfr_pkg::op_entry_t   q_entry
);
    import ecfr_pkg::*;

    logic escape_pending_reg;
    logic escape_pending_next;
    logic accept;
    logic is_escape;

    assign rx.ready  = q_ready;
    assign accept    = rx.valid && q_ready;
    assign is_escape = (rx.rx_byte == escape_code);

    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        q_push              = 1'b0;
        q_entry.op          = OP_DATA;
        q_entry.data        = rx.rx_byte;
        if (accept)
        begin
            if (!escape_pending_reg && is_escape)
            begin
                escape_pending_next = 1'b1;
            end
            else if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                q_push              = 1'b1;
                if (is_escape)
                begin
                    q_entry.op = OP_DATA;
                end
                else if (rx.rx_byte == end_code)
                begin
                    q_entry.op = OP_END;
                end
                else
                begin
                    q_entry.op = OP_HEADER;
                end
            end
            else
            begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

    // An arming escape never reaches the queue.
    a_arm_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !escape_pending_reg && is_escape) |-> !q_push)
        else $error("arming escape pushed an operation");

    // The byte after an escape always pushes and clears the flag.
    a_pending_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && escape_pending_reg) |=> !escape_pending_reg)
        else $error("escape flag not cleared by following byte");

endmodule

[rtl/ecfr_queue.sv]
// Short operation queue between the classifier and the executor.
module ecfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ecfr_pkg::op_entry_t push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output ecfr_pkg::op_entry_t pop_entry
);
    import ecfr_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    op_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // The fill level never exceeds the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill level out of range");

    // A push that lands in a full queue would lose an operation.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("push into a full queue");

endmodule

[rtl/ecfr_back.sv]
// Back part: executes queued operations, keeps position and command, drives results.
module ecfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ecfr_pkg::op_entry_t q_entry,
    output logic                q_pop,
    input  logic [7:0]          initial_command,
    ecfr_res_if.source          res
);
    import ecfr_pkg::*;

    logic              res_valid_reg;
    logic              res_valid_next;
    logic              kind_reg;
    logic              kind_next;
    logic [BYTE_W-1:0] payload_reg;
    logic [BYTE_W-1:0] payload_next;
    logic [BYTE_W-1:0] res_pos_reg;
    logic [BYTE_W-1:0] res_pos_next;
    logic [BYTE_W-1:0] res_cmd_reg;
    logic [BYTE_W-1:0] res_cmd_next;
    logic [BYTE_W-1:0] wpos_reg;
    logic [BYTE_W-1:0] wpos_next;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] cmd_next;
    logic              seen_reg;
    logic              seen_next;
    logic [BYTE_W-1:0] wpos_eff;
    logic [BYTE_W-1:0] active_cmd;
    logic              is_header;
    logic              emits;

    assign is_header  = (q_entry.op == OP_HEADER);
    assign q_pop      = q_valid && (is_header || !res_valid_reg || res.ready);
    assign emits      = q_pop && !is_header;
    assign wpos_eff   = (wpos_reg >= WRAP_LIMIT) ? '0 : wpos_reg;
    assign active_cmd = seen_reg ? cmd_reg : initial_command;

    always_comb
    begin
        wpos_next      = wpos_reg;
        cmd_next       = cmd_reg;
        seen_next      = seen_reg;
        res_valid_next = res.ready ? 1'b0 : res_valid_reg;
        kind_next      = kind_reg;
        payload_next   = payload_reg;
        res_pos_next   = res_pos_reg;
        res_cmd_next   = res_cmd_reg;
        if (q_pop)
        begin
            case (q_entry.op)
                OP_DATA:
                begin
                    wpos_next = wpos_eff + 1'b1;
                end
                OP_END:
                begin
                    wpos_next = wpos_eff;
                end
                OP_HEADER:
                begin
                    wpos_next = '0;
                    cmd_next  = q_entry.data;
                    seen_next = 1'b1;
                end
                default:
                begin
                    wpos_next = wpos_reg;
                end
            endcase
        end
        if (emits)
        begin
            res_valid_next = 1'b1;
            kind_next      = (q_entry.op == OP_END) ? KIND_END : KIND_DATA;
            payload_next   = (q_entry.op == OP_END) ? '0 : q_entry.data;
            res_pos_next   = wpos_eff;
            res_cmd_next   = active_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            wpos_reg      <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            wpos_reg      <= wpos_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        kind_reg    <= kind_next;
        payload_reg <= payload_next;
        res_pos_reg <= res_pos_next;
        res_cmd_reg <= res_cmd_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.kind         = kind_reg;
    assign res.payload_byte = payload_reg;
    assign res.position     = res_pos_reg;
    assign res.command_code = res_cmd_reg;

    // A reported position has always been wrapped below the limit.
    a_pos_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_pos_reg < WRAP_LIMIT))
        else $error("result position not wrapped");

    // An end-of-frame result carries a zero data byte.
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && kind_reg == KIND_END) |-> (payload_reg == '0))
        else $error("end of frame with nonzero data byte");

    // A command header restarts the frame at position zero.
    a_header_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && is_header) |=> (seen_reg && wpos_reg == '0))
        else $error("command header did not restart the frame");

endmodule

[rtl/escaped_command_frame_receiver_unit.sv]
// Top level of the escaped command frame receiver: configuration registers and part wiring.
// A byte that yields a result passes through the operation queue and then the output
// register before it shows on the result channel.
// Throughput: one received byte per cycle while the queue has room, through the
// classifier and executor; the two-entry queue lets either side stall alone.
// Reset (rst_n, asynchronous, active low) clears the escape flag, position and queue,
// and loads the three configuration registers with their default codes.
module escaped_command_frame_receiver_unit (
    input  logic      clk,
    input  logic      rst_n,
    ecfr_rx_if.sink   rx,
    ecfr_res_if.source res,
    ecfr_cfg_if.sink  cfg
);
    import ecfr_pkg::*;

    // Configuration registers. The user writes them only while the block is idle, not
    // enforced here; the front and back parts read them directly without any hand-over.
    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] escape_code_next;
    logic [BYTE_W-1:0] end_code_reg;
    logic [BYTE_W-1:0] end_code_next;
    logic [BYTE_W-1:0] init_cmd_reg;
    logic [BYTE_W-1:0] init_cmd_next;
    logic              cfg_write;

    // Operation queue signals between the classifier and the executor.
    logic      q_push;
    logic      q_push_ready;
    op_entry_t q_push_entry;
    logic      q_pop;
    logic      q_pop_valid;
    op_entry_t q_pop_entry;

    // The configuration channel never stalls: every write transaction completes at once.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    always_comb
    begin
        escape_code_next = escape_code_reg;
        end_code_next    = end_code_reg;
        init_cmd_next    = init_cmd_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                CFG_ESCAPE_CODE:     escape_code_next = cfg.data;
                CFG_END_CODE:        end_code_next    = cfg.data;
                CFG_INITIAL_COMMAND: init_cmd_next    = cfg.data;
                default:             escape_code_next = escape_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= ESCAPE_CODE_RST;
            end_code_reg    <= END_CODE_RST;
            init_cmd_reg    <= INITIAL_COMMAND_RST;
        end
        else
        begin
            escape_code_reg <= escape_code_next;
            end_code_reg    <= end_code_next;
            init_cmd_reg    <= init_cmd_next;
        end
    end

    // The front part accepts a byte whenever the queue has room. It resolves escape
    // sequences into data, end-of-frame and command-header operations; an arming
    // escape only sets its flag and enqueues nothing.
    ecfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .escape_code (escape_code_reg),
        .end_code    (end_code_reg),
        .q_ready     (q_push_ready),
        .q_push      (q_push),
        .q_entry     (q_push_entry)
    );

    ecfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_entry  (q_pop_entry)
    );

    // The back part owns the write position and command code. It applies the position
    // wrap before each operation and keeps the initial command register in effect
    // until the first command header has been executed.
    ecfr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_pop_valid),
        .q_entry         (q_pop_entry),
        .q_pop           (q_pop),
        .initial_command (init_cmd_reg),
        .res             (res)
    );

endmodule
